>>> hdl/sfs_pkg.sv
// Package for the splash fade sequencer: sizes, register map and helpers.
// Standalone; used by hdl/splash_fade_sequencer.sv through scoped names.
package sfs_pkg;

    localparam int MAX_SPLASHES = 4;   // entries allowed, 1..8
    localparam int FADE_STEPS   = 16;  // fade intervals per half hold, 1..255
    localparam int NUM_HOLD     = 4;   // hold registers present

    localparam int CNT_W  = 4;         // wide enough for MAX_SPLASHES up to 8
    localparam int ADDR_W = 5;         // eight 32-bit registers

    localparam logic [CNT_W-1:0] SPLASH_LIMIT =
        (MAX_SPLASHES < NUM_HOLD) ? CNT_W'(MAX_SPLASHES) : CNT_W'(NUM_HOLD);

    typedef enum logic [2:0] {
        REG_SPLASH_COUNT = 3'd0,
        REG_HOLD_MS_0    = 3'd1,
        REG_HOLD_MS_1    = 3'd2,
        REG_HOLD_MS_2    = 3'd3,
        REG_HOLD_MS_3    = 3'd4,
        REG_MIN_CONTRAST = 3'd5,
        REG_MAX_CONTRAST = 3'd6,
        REG_FADE_STEP    = 3'd7
    } t_reg_idx;

    typedef enum logic {
        REQ_TICK  = 1'b0,
        REQ_START = 1'b1
    } t_req;

    localparam logic [7:0] FULL_LEVEL = 8'd255;

    // Clamp v into [lo, hi], low bound tested first.
    function automatic logic [7:0] clamp_level(input logic [7:0] v,
                                               input logic [7:0] lo,
                                               input logic [7:0] hi);
        logic [7:0] r;
        if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

>>> hdl/splash_fade_sequencer.sv
// An accepted request passes through the input register, then the result register.
// Throughput: one request per cycle unless i_out_ready stalls; the 32-bit elapsed-time
// subtract and compare between the input and result registers sets the cycle time.
// Reset (i_rst_n low, synchronous): sequencer idle at entry 0, level 255, both
// stages empty; registers return to count 0, holds 0, min 0, max 255, step 16.
// Top level of the splash fade sequencer; depends on hdl/sfs_pkg.sv.
module splash_fade_sequencer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sfs_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // request channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_req_type,
    input  logic [31:0]                 i_now,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [7:0]                  o_contrast,
    output logic                        o_contrast_write,
    output logic [1:0]                  o_splash_slot,
    output logic                        o_splash_begin,
    output logic                        o_active,
    output logic                        o_sequence_done
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [2:0]  r_splash_count;
    logic [15:0] r_hold_ms_0, r_hold_ms_1, r_hold_ms_2, r_hold_ms_3;
    logic [7:0]  r_min_contrast, r_max_contrast, r_fade_step;

    sfs_pkg::t_reg_idx reg_idx;
    logic              cfg_wr;

    assign reg_idx = sfs_pkg::t_reg_idx'(paddr[sfs_pkg::ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_splash_count <= 3'd0;
            r_hold_ms_0    <= 16'd0;
            r_hold_ms_1    <= 16'd0;
            r_hold_ms_2    <= 16'd0;
            r_hold_ms_3    <= 16'd0;
            r_min_contrast <= 8'd0;
            r_max_contrast <= 8'd255;
            r_fade_step    <= 8'd16;
        end else if (cfg_wr) begin
            case (reg_idx)
                sfs_pkg::REG_SPLASH_COUNT: r_splash_count <= pwdata[2:0];
                sfs_pkg::REG_HOLD_MS_0:    r_hold_ms_0    <= pwdata[15:0];
                sfs_pkg::REG_HOLD_MS_1:    r_hold_ms_1    <= pwdata[15:0];
                sfs_pkg::REG_HOLD_MS_2:    r_hold_ms_2    <= pwdata[15:0];
                sfs_pkg::REG_HOLD_MS_3:    r_hold_ms_3    <= pwdata[15:0];
                sfs_pkg::REG_MIN_CONTRAST: r_min_contrast <= pwdata[7:0];
                sfs_pkg::REG_MAX_CONTRAST: r_max_contrast <= pwdata[7:0];
                sfs_pkg::REG_FADE_STEP:    r_fade_step    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Readback, zero-extended.
    always_comb begin
        case (reg_idx)
            sfs_pkg::REG_SPLASH_COUNT: prdata = {29'd0, r_splash_count};
            sfs_pkg::REG_HOLD_MS_0:    prdata = {16'd0, r_hold_ms_0};
            sfs_pkg::REG_HOLD_MS_1:    prdata = {16'd0, r_hold_ms_1};
            sfs_pkg::REG_HOLD_MS_2:    prdata = {16'd0, r_hold_ms_2};
            sfs_pkg::REG_HOLD_MS_3:    prdata = {16'd0, r_hold_ms_3};
            sfs_pkg::REG_MIN_CONTRAST: prdata = {24'd0, r_min_contrast};
            sfs_pkg::REG_MAX_CONTRAST: prdata = {24'd0, r_max_contrast};
            sfs_pkg::REG_FADE_STEP:    prdata = {24'd0, r_fade_step};
            default:                   prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------
    // Handshake: input stage feeds result stage; result stage frees
    // when empty or taken this cycle.
    // ---------------------------------------------------------------
    logic        r_in_valid;
    logic        r_req_type;
    logic [31:0] r_now;
    logic        r_out_valid;

    logic out_free;
    logic in_fire;
    logic proc;

    assign out_free   = !r_out_valid || i_out_ready;
    assign proc       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;
    assign in_fire    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_fire || (r_in_valid && !out_free);
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_req_type <= i_req_type;
            r_now      <= i_now;
        end
    end

    // ---------------------------------------------------------------
    // Sequencer state
    // ---------------------------------------------------------------
    logic        r_running;
    logic [1:0]  r_entry;
    logic        r_fading;
    logic [31:0] r_phase_start;
    logic [7:0]  r_level;

    logic        n_running;
    logic [1:0]  n_entry;
    logic        n_fading;
    logic [31:0] n_phase_start;
    logic [7:0]  n_level;

    // result fields
    logic [7:0] n_contrast;
    logic       n_contrast_write;
    logic       n_splash_begin;
    logic       n_sequence_done;

    // helpers
    logic [sfs_pkg::CNT_W-1:0] cnt_in_use;
    logic [sfs_pkg::CNT_W-1:0] next_entry;
    logic [15:0]               hold_sel;
    logic [14:0]               half;
    logic [14:0]               step_raw;
    logic [14:0]               interval;
    logic [31:0]               elapsed;
    logic [7:0]                dec_level;

    // Entries in use: splash_count capped at the entry limit.
    assign cnt_in_use = ({1'b0, r_splash_count} > sfs_pkg::SPLASH_LIMIT)
                      ? sfs_pkg::SPLASH_LIMIT : {1'b0, r_splash_count};
    assign next_entry = {2'b00, r_entry} + sfs_pkg::CNT_W'(1);

    always_comb begin
        case (r_entry)
            2'd0:    hold_sel = r_hold_ms_0;
            2'd1:    hold_sel = r_hold_ms_1;
            2'd2:    hold_sel = r_hold_ms_2;
            default: hold_sel = r_hold_ms_3;
        endcase
    end

    assign half     = hold_sel[15:1];
    assign step_raw = 15'(half / sfs_pkg::FADE_STEPS);
    assign interval = (step_raw == 15'd0) ? 15'd1 : step_raw;
    assign elapsed  = r_now - r_phase_start;   // wraps mod 2^32
    assign dec_level = (r_level <= r_fade_step) ? r_min_contrast
                                                : (r_level - r_fade_step);

    always_comb begin
        n_running        = r_running;
        n_entry          = r_entry;
        n_fading         = r_fading;
        n_phase_start    = r_phase_start;
        n_level          = r_level;
        n_contrast       = 8'd0;
        n_contrast_write = 1'b0;
        n_splash_begin   = 1'b0;
        n_sequence_done  = 1'b0;

        if (r_req_type == sfs_pkg::REQ_START) begin
            if (cnt_in_use != '0) begin
                n_running        = 1'b1;
                n_entry          = 2'd0;
                n_fading         = 1'b0;
                n_phase_start    = r_now;
                n_level          = r_max_contrast;
                n_contrast       = sfs_pkg::clamp_level(sfs_pkg::FULL_LEVEL,
                                                        r_min_contrast,
                                                        r_max_contrast);
                n_contrast_write = 1'b1;
                n_splash_begin   = 1'b1;
            end else begin
                // empty sequence: report done, nothing drawn
                n_running       = 1'b0;
                n_sequence_done = 1'b1;
            end
        end else if (r_running) begin
            if (!r_fading) begin
                // hold phase: first half of the hold time
                if (elapsed >= {17'd0, half}) begin
                    n_fading      = 1'b1;
                    n_phase_start = r_now;
                end
            end else if (elapsed >= {17'd0, interval}) begin
                n_phase_start    = r_now;
                n_level          = dec_level;
                n_contrast       = sfs_pkg::clamp_level(dec_level, r_min_contrast,
                                                        r_max_contrast);
                n_contrast_write = 1'b1;
                if (dec_level == r_min_contrast) begin
                    if (next_entry >= cnt_in_use) begin
                        n_running       = 1'b0;
                        n_sequence_done = 1'b1;
                    end else begin
                        // next entry starts at full level
                        n_entry        = next_entry[1:0];
                        n_fading       = 1'b0;
                        n_level        = r_max_contrast;
                        n_splash_begin = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running     <= 1'b0;
            r_entry       <= 2'd0;
            r_fading      <= 1'b0;
            r_phase_start <= 32'd0;
            r_level       <= 8'd255;
        end else if (proc) begin
            r_running     <= n_running;
            r_entry       <= n_entry;
            r_fading      <= n_fading;
            r_phase_start <= n_phase_start;
            r_level       <= n_level;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic [7:0] r_contrast;
    logic       r_contrast_write;
    logic [1:0] r_splash_slot;
    logic       r_splash_begin;
    logic       r_active;
    logic       r_sequence_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= proc || (r_out_valid && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_contrast       <= n_contrast;
            r_contrast_write <= n_contrast_write;
            // slot shown while running or when this step begins, ends or writes contrast; else 0
            r_splash_slot    <= (n_running || n_splash_begin || n_sequence_done ||
                                 n_contrast_write) ? n_entry : 2'd0;
            r_splash_begin   <= n_splash_begin;
            r_active         <= n_running;
            r_sequence_done  <= n_sequence_done;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_contrast       = r_contrast;
    assign o_contrast_write = r_contrast_write;
    assign o_splash_slot    = r_splash_slot;
    assign o_splash_begin   = r_splash_begin;
    assign o_active         = r_active;
    assign o_sequence_done  = r_sequence_done;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_begin_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_splash_begin && r_sequence_done))
        else $error("begin and done in one result");

    a_begin_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_splash_begin) |-> r_active)
        else $error("new entry reported while inactive");

    a_done_inactive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_sequence_done) |-> !r_active)
        else $error("done reported while still active");

    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_contrast_write) |-> (r_contrast == 8'd0))
        else $error("contrast value without write");

    a_state_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !proc |=> ($stable(r_running) && $stable(r_level) && $stable(r_entry)))
        else $error("sequencer state moved without a request");

endmodule
